>>> sv/pidip_pkg.sv
// shared types, constants and saturation helper for the pid controller
`timescale 1ns / 1ps

package pidip_pkg;

    // default sample width of setpoint and measured
    localparam int DEF_SAMPLE_WIDTH = 16;

    // gain and scale format
    localparam int GAIN_W         = 16;
    localparam int GAIN_FRAC_BITS = 8;

    // output accumulator format, Q16.16
    localparam int ACC_W    = 32;
    localparam int ACC_FRAC = 16;
    localparam int DRIVE_W  = ACC_W - ACC_FRAC;

    // saturation points of the datapath
    localparam int GSAT_W  = 47;
    localparam int PSAT_W  = 41;
    localparam int INC_W   = 49;
    localparam int WIDE_W  = 64;

    // product alignment to the accumulator fraction
    localparam int SH   = 2 * GAIN_FRAC_BITS - ACC_FRAC;
    localparam int SH_R = (SH > 0) ? SH : 0;
    localparam int SH_L = (SH < 0) ? -SH : 0;

    // register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KD        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SCALE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN   = 3'd6;

    // mode codes
    localparam logic MODE_INC = 1'b0;
    localparam logic MODE_POS = 1'b1;

    // register reset values
    localparam logic signed [GAIN_W-1:0] SCALE_RESET   = 16'sd256;
    localparam logic signed [GAIN_W-1:0] OUT_MAX_RESET = 16'sh7fff;
    localparam logic signed [GAIN_W-1:0] OUT_MIN_RESET = 16'sh8000;

    typedef struct packed {
        logic                     mode;
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic signed [GAIN_W-1:0] out_scale;
        logic signed [GAIN_W-1:0] out_max;
        logic signed [GAIN_W-1:0] out_min;
    } cfg_t;

    // saturate a wide signed value to a signed range of the given bit count
    function automatic logic signed [WIDE_W-1:0] sat_s64(
        input logic signed [WIDE_W-1:0] v,
        input int                       bits
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
        begin
            return hi;
        end
        else if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

endpackage

>>> sv/pid_controller_inc_pos_unit.sv
// top level of the incremental / positional pid controller
`timescale 1ns / 1ps
// drive is valid once the done state commits the result to the output register
// one shared 16 x 47 multiplier is used four times
//   (p, i, d terms and output scale), then normalize, accumulate and clamp steps
// in_ready is high only while the sequencer is idle; a finished drive waits in the output register
// reset clears error history, integral, accumulator and restores register defaults

module pid_controller_inc_pos_unit #(
    parameter int SAMPLE_WIDTH = pidip_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [pidip_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pidip_pkg::GAIN_W-1:0]           cfg_data,
    // sample request
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         setpoint,
    input  logic signed [SAMPLE_WIDTH-1:0]         measured,
    // drive request
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [pidip_pkg::DRIVE_W-1:0]   drive
);

    // error and its differences
    localparam int E_W     = SAMPLE_WIDTH + 1;
    localparam int X_W     = SAMPLE_WIDTH + 3;
    // multiplier wide operand covers the differences, the integral and the saturated gain sum
    localparam int MUL_B_W = (X_W > pidip_pkg::GSAT_W) ? X_W : pidip_pkg::GSAT_W;
    localparam int PROD_W  = pidip_pkg::GAIN_W + MUL_B_W;
    // gain sum: three terms of at most max(X_W, ACC_W) + GAIN_W bits
    localparam int TERM_W  = ((X_W > pidip_pkg::ACC_W) ? X_W : pidip_pkg::ACC_W)
                             + pidip_pkg::GAIN_W;
    localparam int GSUM_W  = TERM_W + 2;
    localparam int ACC_W   = pidip_pkg::ACC_W;
    localparam int WIDE_W  = pidip_pkg::WIDE_W;
    localparam int INC_W   = pidip_pkg::INC_W;

    // sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;  // waiting for a sample
    localparam logic [3:0] ST_P     = 4'd1;  // integral update, issue kp term
    localparam logic [3:0] ST_I     = 4'd2;  // issue ki term
    localparam logic [3:0] ST_D     = 4'd3;  // issue kd term
    localparam logic [3:0] ST_SUM   = 4'd4;  // last term into the gain sum
    localparam logic [3:0] ST_SCALE = 4'd5;  // issue out_scale times saturated sum
    localparam logic [3:0] ST_NORM  = 4'd6;  // align product to Q16.16 and saturate
    localparam logic [3:0] ST_ADD   = 4'd7;  // add increment or take position
    localparam logic [3:0] ST_DONE  = 4'd8;  // clamp and commit once output slot is free

    pidip_pkg::cfg_t cfg_q;

    logic [3:0]                    state_reg;
    logic [3:0]                    state_next;

    // controller state
    logic signed [E_W-1:0]         e1_reg;
    logic signed [E_W-1:0]         e2_reg;
    logic signed [ACC_W-1:0]       integ_reg;
    logic signed [ACC_W-1:0]       integ_next;
    logic signed [ACC_W-1:0]       out_acc_reg;

    // per-sample working registers
    logic signed [E_W-1:0]         e_reg;
    logic signed [GSUM_W-1:0]      gsum_reg;
    logic signed [INC_W-1:0]       scaled_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    // output register
    logic                          out_valid_reg;
    logic signed [pidip_pkg::DRIVE_W-1:0] drive_reg;

    logic                          accept;
    logic                          commit;
    logic signed [E_W-1:0]         e_in;
    logic signed [X_W-1:0]         d1;
    logic signed [X_W-1:0]         d2;
    logic signed [pidip_pkg::GAIN_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]      prod;
    logic signed [WIDE_W-1:0]      gsat;
    logic signed [WIDE_W-1:0]      prod_w;
    logic signed [WIDE_W-1:0]      scaled_w;
    logic signed [WIDE_W-1:0]      norm_w;
    logic signed [WIDE_W-1:0]      sum_w;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [ACC_W-1:0]       clamp_hi;
    logic signed [ACC_W-1:0]       clamp_lo;
    logic signed [ACC_W-1:0]       after_hi;
    logic signed [ACC_W-1:0]       clamped;

    pidip_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg_q)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign commit   = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // error of the new sample, one bit wider than the samples
    assign e_in = E_W'(setpoint) - E_W'(measured);

    // first and second differences against the held history
    assign d1 = X_W'(e_reg) - X_W'(e1_reg);
    assign d2 = X_W'(e_reg) - (X_W'(e1_reg) <<< 1) + X_W'(e2_reg);

    // integral saturates to 32 bits, positional mode only
    assign integ_next = ACC_W'(pidip_pkg::sat_s64(WIDE_W'(integ_reg) + WIDE_W'(e_reg),
                                                   pidip_pkg::ACC_W));

    // gain sum saturated before scaling
    assign gsat = pidip_pkg::sat_s64(WIDE_W'(gsum_reg), pidip_pkg::GSAT_W);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_P:
            begin
                mul_a = cfg_q.kp;
                mul_b = (cfg_q.mode == pidip_pkg::MODE_POS) ? MUL_B_W'(e_reg) : MUL_B_W'(d1);
            end
            ST_I:
            begin
                mul_a = cfg_q.ki;
                mul_b = (cfg_q.mode == pidip_pkg::MODE_POS) ? MUL_B_W'(integ_reg)
                                                            : MUL_B_W'(e_reg);
            end
            ST_D:
            begin
                mul_a = cfg_q.kd;
                mul_b = (cfg_q.mode == pidip_pkg::MODE_POS) ? MUL_B_W'(d1) : MUL_B_W'(d2);
            end
            ST_SCALE:
            begin
                mul_a = cfg_q.out_scale;
                mul_b = MUL_B_W'(gsat);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pidip_mul #(
        .B_W (MUL_B_W)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // bring the scaled product to 16 fraction bits: floor on right shift,
    // saturate to 41 bits before a left shift
    assign prod_w = WIDE_W'(prod);
    always_comb
    begin
        if (pidip_pkg::SH >= 0)
        begin
            scaled_w = prod_w >>> pidip_pkg::SH_R;
        end
        else
        begin
            scaled_w = pidip_pkg::sat_s64(prod_w, pidip_pkg::PSAT_W) <<< pidip_pkg::SH_L;
        end
    end

    // positional output saturates to 32 bits, an increment to 49 bits
    assign norm_w = (cfg_q.mode == pidip_pkg::MODE_POS)
                    ? pidip_pkg::sat_s64(scaled_w, pidip_pkg::ACC_W)
                    : pidip_pkg::sat_s64(scaled_w, pidip_pkg::INC_W);

    // incremental mode adds to the held accumulator
    assign sum_w    = WIDE_W'(out_acc_reg) + WIDE_W'(scaled_reg);
    assign acc_next = (cfg_q.mode == pidip_pkg::MODE_POS)
                      ? ACC_W'(scaled_reg)
                      : ACC_W'(pidip_pkg::sat_s64(sum_w, pidip_pkg::ACC_W));

    // upper clamp first, then lower clamp; a clamped value has no fraction
    assign clamp_hi = {cfg_q.out_max, {pidip_pkg::ACC_FRAC{1'b0}}};
    assign clamp_lo = {cfg_q.out_min, {pidip_pkg::ACC_FRAC{1'b0}}};
    assign after_hi = (acc_reg > clamp_hi) ? clamp_hi : acc_reg;
    assign clamped  = (after_hi < clamp_lo) ? clamp_lo : after_hi;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = accept ? ST_P : ST_IDLE;
            ST_P:     state_next = ST_I;
            ST_I:     state_next = ST_D;
            ST_D:     state_next = ST_SUM;
            ST_SUM:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_NORM;
            ST_NORM:  state_next = ST_ADD;
            ST_ADD:   state_next = ST_DONE;
            ST_DONE:  state_next = commit ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            e1_reg        <= '0;
            e2_reg        <= '0;
            integ_reg     <= '0;
            out_acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_P) && (cfg_q.mode == pidip_pkg::MODE_POS))
            begin
                integ_reg <= integ_next;
            end
            if (commit)
            begin
                out_acc_reg   <= clamped;
                e2_reg        <= e1_reg;
                e1_reg        <= e_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_reg    <= e_in;
            gsum_reg <= '0;
        end
        if ((state_reg == ST_I) || (state_reg == ST_D) || (state_reg == ST_SUM))
        begin
            gsum_reg <= gsum_reg + GSUM_W'(prod);
        end
        if (state_reg == ST_NORM)
        begin
            scaled_reg <= INC_W'(norm_w);
        end
        if (state_reg == ST_ADD)
        begin
            acc_reg <= acc_next;
        end
        if (commit)
        begin
            drive_reg <= clamped[ACC_W-1:pidip_pkg::ACC_FRAC];
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // a sample is never taken while another is being worked on
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sample accepted while sequencer busy");

    // a finished result waits without disturbing the pending drive
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid && !out_ready)
        |=> (state_reg == ST_DONE) && $stable(drive) && out_valid)
        else $error("pending drive overwritten");

    // with an ordered range the drive stays inside the clamp limits
    a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ($signed(cfg_q.out_min) <= $signed(cfg_q.out_max)))
        |-> (($signed(drive) >= $signed(cfg_q.out_min))
             && ($signed(drive) <= $signed(cfg_q.out_max))))
        else $error("drive outside clamp range");

    // the integral only moves in positional mode
    a_integral_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_q.mode == pidip_pkg::MODE_INC && $stable(cfg_q.mode)) |=> $stable(integ_reg))
        else $error("integral changed in incremental mode");

endmodule

>>> sv/pidip_cfg.sv
// configuration register file of the pid controller
`timescale 1ns / 1ps

module pidip_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pidip_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidip_pkg::GAIN_W-1:0]         cfg_data,
    output pidip_pkg::cfg_t                      cfg
);

    pidip_pkg::cfg_t cfg_reg;
    pidip_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pidip_pkg::REG_MODE:      cfg_next.mode      = cfg_data[0];
                pidip_pkg::REG_KP:        cfg_next.kp        = $signed(cfg_data);
                pidip_pkg::REG_KI:        cfg_next.ki        = $signed(cfg_data);
                pidip_pkg::REG_KD:        cfg_next.kd        = $signed(cfg_data);
                pidip_pkg::REG_OUT_SCALE: cfg_next.out_scale = $signed(cfg_data);
                pidip_pkg::REG_OUT_MAX:   cfg_next.out_max   = $signed(cfg_data);
                pidip_pkg::REG_OUT_MIN:   cfg_next.out_min   = $signed(cfg_data);
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= pidip_pkg::MODE_INC;
            cfg_reg.kp        <= '0;
            cfg_reg.ki        <= '0;
            cfg_reg.kd        <= '0;
            cfg_reg.out_scale <= pidip_pkg::SCALE_RESET;
            cfg_reg.out_max   <= pidip_pkg::OUT_MAX_RESET;
            cfg_reg.out_min   <= pidip_pkg::OUT_MIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/pidip_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module pidip_mul #(
    parameter int B_W = pidip_pkg::GSAT_W
) (
    input  logic                                      clk,
    input  logic signed [pidip_pkg::GAIN_W-1:0]       a,
    input  logic signed [B_W-1:0]                     b,
    output logic signed [pidip_pkg::GAIN_W+B_W-1:0]   prod
);

    logic signed [pidip_pkg::GAIN_W+B_W-1:0] prod_reg;
    logic signed [pidip_pkg::GAIN_W+B_W-1:0] prod_next;

    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule
